FILE: hdl/bloom_filter_string_membership_defines.svh
// assertion macros for the bloom filter block
`ifndef BLOOM_FILTER_STRING_MEMBERSHIP_DEFINES_SVH
`define BLOOM_FILTER_STRING_MEMBERSHIP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BFSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BFSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/bfsm_pkg.sv
// constants and types for the bloom filter block
package bfsm_pkg;

	localparam int unsigned MAX_BYTES  = 4096;
	localparam int unsigned MAX_HASHES = 16;
	localparam int unsigned ADDR_W     = $clog2(MAX_BYTES);
	localparam int unsigned FB_W       = 13;
	localparam int unsigned K_W        = 5;
	localparam int unsigned BITS_W     = ADDR_W + 4;
	localparam int unsigned REM_W      = ADDR_W + 3;
	localparam int unsigned DIV_STEPS  = 64;
	localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

	localparam logic [31:0] DJB_SEED = 32'd5381;

	// configuration register indexes
	localparam logic REG_NUM_HASHES   = 1'b0;
	localparam logic REG_FILTER_BYTES = 1'b1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_DIV   = 5'b00100,
		S_RD    = 5'b01000,
		S_MEM   = 5'b10000
	} state_t;

endpackage

FILE: hdl/bloom_filter_string_membership.sv
// bloom filter string membership: byte hashing, index remainder unit and bit store
//
// A string arrives one byte per transaction (start high while busy is low). A byte
// that is not the last only updates the hashes and busy stays low. The last byte
// starts the probe of k = min(num_hashes, 16) indices: each index passes through the
// shared one-bit-per-cycle remainder unit and then the bit store (read, then check
// or read-modify-write), and the string ends with done high for exactly one cycle
// carrying found and was_search. With k = 0 the result is registered and follows in
// the cycle after the last byte. The receiver cannot stall: done is a one-cycle
// strobe. After reset the block clears its 4096-byte store, one byte a cycle, and
// holds busy high while it clears; configuration writes are taken during that time.
// Write configuration only while the block is idle.
`include "bloom_filter_string_membership_defines.svh"

module bloom_filter_string_membership
	import bfsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [FB_W-1:0]   cfg_data,
	input  logic              start,
	input  logic              opcode,
	input  logic [7:0]        char_byte,
	input  logic              last_byte,
	output logic              busy,
	output logic              done,
	output logic              found,
	output logic              was_search
);

	state_t              state_q;
	logic [K_W-1:0]      num_hashes_q;
	logic [FB_W-1:0]     filter_bytes_q;
	logic [31:0]         djb_q;
	logic [63:0]         sdbm_q;
	logic [63:0]         h_q;
	logic [63:0]         div_q;
	logic [REM_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [K_W-1:0]      idx_q;
	logic [K_W-1:0]      k_q;
	logic [BITS_W-1:0]   bits_q;
	logic                op_q;
	logic                hit_q;
	logic [ADDR_W-1:0]   clr_q;
	logic                done_q;
	logic                found_q;
	logic                was_search_q;

	logic [7:0]          mem [MAX_BYTES];
	logic [7:0]          rd_data_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [7:0]          mem_wdata;

	logic                accept;
	logic [31:0]         djb_nxt;
	logic [63:0]         sdbm_nxt;
	logic [K_W-1:0]      k_use;
	logic [FB_W-1:0]     fb_use;
	logic [BITS_W-1:0]   bits_use;
	logic [BITS_W-1:0]   trial;
	logic [REM_W-1:0]    rem_nxt;
	logic [7:0]          bit_mask;
	logic                hit_nxt;
	logic [K_W-1:0]      idx_nxt;
	logic [63:0]         h_nxt;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign done       = done_q;
	assign found      = found_q;
	assign was_search = was_search_q;

	// per-byte hash update
	assign djb_nxt  = (djb_q << 5) + djb_q + {24'd0, char_byte};
	assign sdbm_nxt = {56'd0, char_byte} + (sdbm_q << 6) + (sdbm_q << 16) - sdbm_q;

	always_comb begin
		k_use = (num_hashes_q > K_W'(MAX_HASHES)) ? K_W'(MAX_HASHES) : num_hashes_q;
		if (filter_bytes_q == '0) begin
			fb_use = FB_W'(1);
		end else if (filter_bytes_q > FB_W'(MAX_BYTES)) begin
			fb_use = FB_W'(MAX_BYTES);
		end else begin
			fb_use = filter_bytes_q;
		end
	end
	assign bits_use = BITS_W'({fb_use, 3'b000});

	// restoring remainder step, one dividend bit per cycle
	assign trial   = {rem_q, div_q[63]};
	assign rem_nxt = (trial >= bits_q) ? REM_W'(trial - bits_q) : trial[REM_W-1:0];

	assign bit_mask = 8'd1 << rem_q[2:0];
	assign hit_nxt  = hit_q && rd_data_q[rem_q[2:0]];
	assign idx_nxt  = idx_q + K_W'(1);
	// next index differs by sdbm + 2i + 1
	assign h_nxt    = h_q + sdbm_q + 64'({idx_q, 1'b1});

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 8'd0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == S_MEM && op_q == OP_INSERT) begin
			mem_we    = 1'b1;
			mem_waddr = rem_q[REM_W-1:3];
			mem_wdata = rd_data_q | bit_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rem_q[REM_W-1:3]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_hashes_q   <= K_W'(3);
			filter_bytes_q <= FB_W'(MAX_BYTES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_HASHES:   num_hashes_q   <= cfg_data[K_W-1:0];
				REG_FILTER_BYTES: filter_bytes_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			djb_q        <= DJB_SEED;
			sdbm_q       <= '0;
			done_q       <= 1'b0;
			found_q      <= 1'b0;
			was_search_q <= 1'b0;
			idx_q        <= '0;
			k_q          <= '0;
			cnt_q        <= '0;
			h_q          <= '0;
			div_q        <= '0;
			rem_q        <= '0;
			bits_q       <= '0;
			op_q         <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(MAX_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (!last_byte) begin
							djb_q  <= djb_nxt;
							sdbm_q <= sdbm_nxt;
						end else if (k_use == '0) begin
							djb_q        <= DJB_SEED;
							sdbm_q       <= '0;
							done_q       <= 1'b1;
							found_q      <= 1'b1;
							was_search_q <= opcode;
						end else begin
							djb_q   <= DJB_SEED;
							sdbm_q  <= sdbm_nxt;
							h_q     <= {32'd0, djb_nxt};
							div_q   <= {32'd0, djb_nxt};
							rem_q   <= '0;
							cnt_q   <= CNT_W'(DIV_STEPS - 1);
							idx_q   <= '0;
							k_q     <= k_use;
							bits_q  <= bits_use;
							op_q    <= opcode;
							hit_q   <= 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q <= rem_nxt;
					div_q <= {div_q[62:0], 1'b0};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_MEM;
				end
				S_MEM: begin
					if (op_q == OP_SEARCH) begin
						hit_q <= hit_nxt;
					end
					if (idx_nxt == k_q) begin
						done_q       <= 1'b1;
						found_q      <= (op_q == OP_INSERT) || hit_nxt;
						was_search_q <= op_q;
						sdbm_q       <= '0;
						state_q      <= S_IDLE;
					end else begin
						idx_q   <= idx_nxt;
						h_q     <= h_nxt;
						div_q   <= h_nxt;
						rem_q   <= '0;
						cnt_q   <= CNT_W'(DIV_STEPS - 1);
						state_q <= S_DIV;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BFSM_ASSERT_NOW(a_no_result_in_clear, state_q == S_CLEAR, !done_q, "result during clear")
	`BFSM_ASSERT_NOW(a_rem_in_range, state_q == S_RD, BITS_W'(rem_q) < bits_q,
		"remainder out of range")
	`BFSM_ASSERT_NOW(a_idx_in_range, state_q == S_MEM, idx_q < k_q, "probe index past k")
	`BFSM_ASSERT_NEXT(a_last_starts_probe, accept && last_byte && k_use != '0,
		state_q == S_DIV && !done_q, "last byte did not start probe")

endmodule
